// ----- rtl/ebf_pkg.sv -----
// Shared types and constants for the enhanced packet block framer.
// Used by every module of the framer; depends on nothing else.
package ebf_pkg;

    // Item kinds on the input channel. The fourth code means nothing and is ignored.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Capacity of one block in packet bytes, and the widths that follow from it.
    localparam int MAX_PACKET_BYTES = 65504;
    localparam int BC_W             = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ADDR_W           = 14;

    // Block layout.
    localparam logic [31:0]       BLOCK_TYPE_EPB = 32'd6;
    localparam logic [31:0]       HDR_BYTES      = 32'd32;
    localparam logic [ADDR_W-1:0] DATA_BASE      = ADDR_W'(7);
    localparam logic [ADDR_W-1:0] ADDR_TYPE      = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_TOTAL     = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_IFACE     = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_TS_HI     = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] ADDR_TS_LO     = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] ADDR_CAPLEN    = ADDR_W'(5);
    localparam logic [ADDR_W-1:0] ADDR_PKTLEN    = ADDR_W'(6);

    // Command queue depth.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // One command from the front to the back: a finished data word or a block close.
    typedef struct packed {
        logic              finish;
        logic              trunc;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic [BC_W-1:0]   byte_count;
        logic [23:0]       partial;
        logic [31:0]       iface;
        logic [63:0]       timestamp;
    } t_cmd;

    // Word sequencer of the back part.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DATA,
        ST_PART,
        ST_TRAIL,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_H6
    } t_step;

endpackage

// ----- rtl/ebf_front.sv -----
// Front part of the framer: takes input items, tracks the open block and
// pushes data-word and block-close commands. Depends on ebf_pkg.
module ebf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [1:0]                   i_kind,
    input  logic [31:0]                  i_iface,
    input  logic [63:0]                  i_timestamp,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_push,
    output ebf_pkg::t_cmd                o_cmd
);

    logic                     r_open, n_open;
    logic                     r_ovf, n_ovf;
    logic [ebf_pkg::BC_W-1:0] r_bc, n_bc;
    logic [23:0]              r_partial, n_partial;
    logic [31:0]              r_iface, n_iface;
    logic [63:0]              r_ts, n_ts;
    logic [ebf_pkg::BC_W-1:0] bc_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_ovf     <= 1'b0;
            r_bc      <= '0;
            r_partial <= '0;
            r_iface   <= '0;
            r_ts      <= '0;
        end else begin
            r_open    <= n_open;
            r_ovf     <= n_ovf;
            r_bc      <= n_bc;
            r_partial <= n_partial;
            r_iface   <= n_iface;
            r_ts      <= n_ts;
        end
    end

    assign bc_inc = r_bc + 1'b1;

    always_comb begin
        n_open    = r_open;
        n_ovf     = r_ovf;
        n_bc      = r_bc;
        n_partial = r_partial;
        n_iface   = r_iface;
        n_ts      = r_ts;
        o_push    = 1'b0;

        o_cmd            = '0;
        o_cmd.trunc      = r_ovf;
        o_cmd.byte_count = r_bc;
        o_cmd.partial    = r_partial;
        o_cmd.iface      = r_iface;
        o_cmd.timestamp  = r_ts;
        o_cmd.data       = {i_data_byte, r_partial};
        o_cmd.addr       = ebf_pkg::ADDR_W'(bc_inc >> 2) + ebf_pkg::ADDR_PKTLEN;

        if (i_accept) begin
            case (i_kind)
                ebf_pkg::KIND_START: begin
                    n_open    = 1'b1;
                    n_ovf     = 1'b0;
                    n_bc      = '0;
                    n_partial = '0;
                    n_iface   = i_iface;
                    n_ts      = i_timestamp;
                end
                ebf_pkg::KIND_DATA: begin
                    if (r_open) begin
                        if (r_bc >= ebf_pkg::BC_W'(ebf_pkg::MAX_PACKET_BYTES)) begin
                            // A full block drops the byte and remembers it.
                            n_ovf = 1'b1;
                        end else begin
                            n_bc = bc_inc;
                            if (r_bc[1:0] == 2'd3) begin
                                n_partial = '0;
                                o_push    = 1'b1;
                            end else begin
                                n_partial = r_partial
                                          | (24'(i_data_byte) << {r_bc[1:0], 3'b000});
                            end
                        end
                    end
                end
                ebf_pkg::KIND_DONE: begin
                    if (r_open) begin
                        o_cmd.finish = 1'b1;
                        o_push       = 1'b1;
                        n_open       = 1'b0;
                        n_partial    = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/ebf_queue.sv -----
// Short command queue between the front and back parts of the framer.
// The head is visible without a read request. Depends on ebf_pkg.
module ebf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ebf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nonempty,
    output ebf_pkg::t_cmd o_head
);

    ebf_pkg::t_cmd                r_mem [ebf_pkg::Q_DEPTH];
    logic [ebf_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [ebf_pkg::Q_PTR_W:0]    r_cnt;

    assign o_full     = (r_cnt == (ebf_pkg::Q_PTR_W + 1)'(ebf_pkg::Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/ebf_back.sv -----
// Back part: turns queued commands into block words in the output register,
// one word per cycle while the receiver is ready. Depends on ebf_pkg.
module ebf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_nonempty,
    input  ebf_pkg::t_cmd                     i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ebf_pkg::ADDR_W-1:0]        o_word_addr,
    output logic [31:0]                       o_word_data,
    output logic                              o_truncated,
    output logic                              o_last_word
);

    ebf_pkg::t_step              r_step, n_step;
    ebf_pkg::t_step              act_step, nxt_step;
    ebf_pkg::t_cmd               r_cur, n_cur;
    ebf_pkg::t_cmd               act;
    logic                        have, adv, emit;
    logic                        r_valid;
    logic [ebf_pkg::ADDR_W-1:0]  r_addr, g_addr;
    logic [31:0]                 r_data, g_data;
    logic                        r_trunc, r_last, g_last;
    logic [ebf_pkg::BC_W-2:0]    words;
    logic [31:0]                 total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ebf_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (adv) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (emit) begin
            r_addr  <= g_addr;
            r_data  <= g_data;
            r_trunc <= act.trunc;
            r_last  <= g_last;
        end
    end

    // Pick the command in work: the held close command, or the queue head.
    always_comb begin
        if (r_step == ebf_pkg::ST_IDLE) begin
            act  = i_head;
            have = i_nonempty;
            if (!i_head.finish) begin
                act_step = ebf_pkg::ST_DATA;
            end else if (i_head.byte_count[1:0] != 2'd0) begin
                act_step = ebf_pkg::ST_PART;
            end else begin
                act_step = ebf_pkg::ST_TRAIL;
            end
        end else begin
            act      = r_cur;
            have     = 1'b1;
            act_step = r_step;
        end
    end

    assign adv   = !r_valid || i_ready;
    assign emit  = adv && have;
    assign o_pop = emit && (r_step == ebf_pkg::ST_IDLE);

    // Word count rounds the kept bytes up to whole words.
    assign words = (ebf_pkg::BC_W - 1)'(({1'b0, act.byte_count} + 3'd3) >> 2);
    assign total = ebf_pkg::HDR_BYTES + (32'(words) << 2);

    always_comb begin
        g_addr   = act.addr;
        g_data   = act.data;
        g_last   = 1'b0;
        nxt_step = ebf_pkg::ST_IDLE;
        case (act_step)
            ebf_pkg::ST_DATA: begin
                nxt_step = ebf_pkg::ST_IDLE;
            end
            ebf_pkg::ST_PART: begin
                g_addr   = ebf_pkg::ADDR_W'(act.byte_count >> 2) + ebf_pkg::DATA_BASE;
                g_data   = {8'd0, act.partial};
                nxt_step = ebf_pkg::ST_TRAIL;
            end
            ebf_pkg::ST_TRAIL: begin
                g_addr   = ebf_pkg::ADDR_W'(words) + ebf_pkg::DATA_BASE;
                g_data   = total;
                nxt_step = ebf_pkg::ST_H0;
            end
            ebf_pkg::ST_H0: begin
                g_addr   = ebf_pkg::ADDR_TYPE;
                g_data   = ebf_pkg::BLOCK_TYPE_EPB;
                nxt_step = ebf_pkg::ST_H1;
            end
            ebf_pkg::ST_H1: begin
                g_addr   = ebf_pkg::ADDR_TOTAL;
                g_data   = total;
                nxt_step = ebf_pkg::ST_H2;
            end
            ebf_pkg::ST_H2: begin
                g_addr   = ebf_pkg::ADDR_IFACE;
                g_data   = act.iface;
                nxt_step = ebf_pkg::ST_H3;
            end
            ebf_pkg::ST_H3: begin
                g_addr   = ebf_pkg::ADDR_TS_HI;
                g_data   = act.timestamp[63:32];
                nxt_step = ebf_pkg::ST_H4;
            end
            ebf_pkg::ST_H4: begin
                g_addr   = ebf_pkg::ADDR_TS_LO;
                g_data   = act.timestamp[31:0];
                nxt_step = ebf_pkg::ST_H5;
            end
            ebf_pkg::ST_H5: begin
                g_addr   = ebf_pkg::ADDR_CAPLEN;
                g_data   = 32'(act.byte_count);
                nxt_step = ebf_pkg::ST_H6;
            end
            ebf_pkg::ST_H6: begin
                g_addr   = ebf_pkg::ADDR_PKTLEN;
                g_data   = 32'(act.byte_count);
                g_last   = 1'b1;
                nxt_step = ebf_pkg::ST_IDLE;
            end
            default: begin
                nxt_step = ebf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_step = r_step;
        n_cur  = r_cur;
        if (emit) begin
            n_step = nxt_step;
            n_cur  = act;
        end
    end

    assign o_valid     = r_valid;
    assign o_word_addr = r_addr;
    assign o_word_data = r_data;
    assign o_truncated = r_trunc;
    assign o_last_word = r_last;

endmodule

// ----- rtl/enhanced_packet_block_framer_core.sv -----
// Top level of the enhanced packet block framer.
// Instantiates ebf_front, ebf_queue and ebf_back; depends on ebf_pkg.
//
// Usage:
// The input channel (i_valid / o_ready) carries items of three kinds: a start
// item opens a block and latches the interface id and timestamp, a data item
// adds one packet byte, and a done item closes the block. The output channel
// (o_valid / i_ready) carries the block as 32-bit little-endian words, each
// with its word offset inside the block, a truncation flag and a last-word
// flag on the packet-length header word that ends every block.
// Data words leave in order as they fill, starting at offset 7; a done item
// then yields the padded partial word if any, the trailing total length and
// the seven header words at offsets 0 to 6, in that order.
// A word is written into the command queue at the transfer of the item that
// completes it, and the back part then moves it into the output register.
// Throughput: one input transfer per cycle while the command queue has room,
// and one output word per cycle while the receiver is ready; a done item
// yields 8 or 9 output words from the sequencer, which the four-entry command
// queue between the front and back parts absorbs.
// Reset (synchronous, active low) closes any open block, empties the queue
// and drops the output valid. When the receiver stalls, the output word holds
// in its register, the queue fills, and o_ready falls once it is full.
module enhanced_packet_block_framer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_kind,
    input  logic [31:0]                i_iface,
    input  logic [63:0]                i_timestamp,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ebf_pkg::ADDR_W-1:0] o_word_addr,
    output logic [31:0]                o_word_data,
    output logic                       o_truncated,
    output logic                       o_last_word
);

    logic          accept;
    logic          push, pop, q_full, q_nonempty;
    ebf_pkg::t_cmd push_cmd, head_cmd;

    // The front never needs more than one queue slot per transfer, so a
    // free slot is all it takes to accept the next item.
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    ebf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_iface     (i_iface),
        .i_timestamp (i_timestamp),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    ebf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    ebf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word_addr (o_word_addr),
        .o_word_data (o_word_data),
        .o_truncated (o_truncated),
        .o_last_word (o_last_word)
    );

endmodule

// ----- rtl/ebf_checker.sv -----
// Port-level checks for the enhanced packet block framer, and the bind that
// attaches them to the top level. Depends on ebf_pkg.
module ebf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [ebf_pkg::ADDR_W-1:0] o_word_addr,
    input logic [31:0]                o_word_data,
    input logic                       o_last_word
);

    // The last word of a block is always the packet-length header word.
    a_last_is_pktlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |-> (o_word_addr == ebf_pkg::ADDR_PKTLEN))
        else $error("last word not at packet length offset");

    // The type word always carries the enhanced packet block type.
    a_type_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word_addr == ebf_pkg::ADDR_TYPE) |->
        (o_word_data == ebf_pkg::BLOCK_TYPE_EPB))
        else $error("wrong block type word");

    // A word held by a stalled receiver stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word_data)
                                   && $stable(o_word_addr)))
        else $error("output word changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind enhanced_packet_block_framer_core ebf_checker u_ebf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_word_addr (o_word_addr),
    .o_word_data (o_word_data),
    .o_last_word (o_last_word)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the framer top level, enhanced_packet_block_framer_core.
// Drives start, data and done items, predicts the block words, checks every output transfer.
// Depends on ebf_pkg and the framer RTL.
`timescale 1ns / 100ps

module tb_top;

    // The fourth kind code has no meaning and the block ignores it.
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    localparam int RAND_ITEMS     = 280;
    localparam int NUM_ROWS       = 25;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_WORDS      = 9;

    // Receiver stall patterns.
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    typedef struct packed {
        logic [ebf_pkg::ADDR_W-1:0] addr;
        logic [31:0]                data;
        logic                       trunc;
        logic                       last;
    } t_block_word;

    // One directed row. Where typed is set, n_words and the first word are read straight
    // off the block format and cross-check the predictor.
    typedef struct packed {
        logic [1:0]                 kind;
        logic [31:0]                iface;
        logic [63:0]                ts;
        logic [7:0]                 data_byte;
        logic                       typed;
        logic [3:0]                 n_words;
        logic [ebf_pkg::ADDR_W-1:0] addr;
        logic [31:0]                data;
    } t_stim_row;

    localparam t_stim_row STIM_TAB [NUM_ROWS] = '{
        // Data and done with no open block, and the undefined kind, do nothing.
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'hFF, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{KIND_UNDEF,          32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 4'd0,
          14'd0, 32'h0},
        // An empty packet: trailer at offset 7 with total length 32, then seven headers.
        '{ebf_pkg::KIND_START, 32'h0,         64'h0,                   8'h00, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b1, 4'd8,
          14'd7, 32'd32},
        // All-ones header fields, one full word and a one-byte partial word.
        '{ebf_pkg::KIND_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'hFF, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h00, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'hA5, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h5A, 1'b1, 4'd1,
          14'd7, 32'h5AA5_00FF},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h01, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{KIND_UNDEF,          32'h0,         64'h0,                   8'h77, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b1, 4'd9,
          14'd8, 32'h1},
        // A start inside an open block abandons it without output.
        '{ebf_pkg::KIND_START, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h11, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h22, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_START, 32'hCAFE_F00D, 64'h8000_0000_0000_0001, 8'h00, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h33, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h44, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h55, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b1, 4'd9,
          14'd7, 32'h0055_4433},
        // A second done finds the block closed.
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b1, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_START, 32'h0000_0001, 64'h0000_0000_0000_0001, 8'h00, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DATA,  32'h0,         64'h0,                   8'h80, 1'b0, 4'd0,
          14'd0, 32'h0},
        '{ebf_pkg::KIND_DONE,  32'h0,         64'h0,                   8'h00, 1'b0, 4'd0,
          14'd0, 32'h0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_kind;
    logic [31:0]                i_iface;
    logic [63:0]                i_timestamp;
    logic [7:0]                 i_data_byte;
    logic                       o_valid;
    logic                       i_ready;
    logic [ebf_pkg::ADDR_W-1:0] o_word_addr;
    logic [31:0]                o_word_data;
    logic                       o_truncated;
    logic                       o_last_word;

    // Predictor state: a copy of what the framer holds for the open block.
    logic                       pr_open;
    logic [16:0]                pr_count;
    logic [23:0]                pr_partial;
    logic [31:0]                pr_iface;
    logic [63:0]                pr_ts;
    logic                       pr_overflow;

    t_block_word                pending_words [$];
    int                         n_fail      = 0;
    int                         n_row_fail  = 0;
    int                         items_taken = 0;
    int                         burst_left  = 0;
    int                         idle_cycles = 0;
    int                         hold_reqs   = 0;

    enhanced_packet_block_framer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_iface     (i_iface),
        .i_timestamp (i_timestamp),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word_addr (o_word_addr),
        .o_word_data (o_word_data),
        .o_truncated (o_truncated),
        .o_last_word (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_block_word mk_word(input int addr, input logic [31:0] data,
                                            input logic last);
        t_block_word w;
        w.addr  = ebf_pkg::ADDR_W'(addr);
        w.data  = data;
        w.trunc = pr_overflow;
        w.last  = last;
        return w;
    endfunction

    // Works out the block words one accepted item causes and advances the predictor state.
    // effective is cleared for items the block ignores.
    task automatic predict_block_words(input logic [1:0] kind, input logic [31:0] iface,
                                       input logic [63:0] ts, input logic [7:0] data_byte,
                                       output t_block_word words [MAX_WORDS], output int n,
                                       output bit effective);
        int          n_data_words;
        logic [31:0] total;
        logic [1:0]  pos;
        n         = 0;
        effective = 1'b0;
        words     = '{default: '0};
        if (kind == ebf_pkg::KIND_START) begin
            effective   = 1'b1;
            pr_open     = 1'b1;
            pr_count    = '0;
            pr_partial  = '0;
            pr_overflow = 1'b0;
            pr_iface    = iface;
            pr_ts       = ts;
        end else if (pr_open && kind != KIND_UNDEF) begin
            effective = 1'b1;
            if (kind == ebf_pkg::KIND_DATA) begin
                if (pr_count >= 17'(ebf_pkg::MAX_PACKET_BYTES)) begin
                    // The block is full: the byte is dropped and the block marked truncated.
                    pr_overflow = 1'b1;
                end else begin
                    pos      = pr_count[1:0];
                    pr_count = pr_count + 17'd1;
                    if (pos == 2'd3) begin
                        words[0]   = mk_word(int'(ebf_pkg::DATA_BASE) + int'(pr_count >> 2) - 1,
                                             {data_byte, pr_partial}, 1'b0);
                        n          = 1;
                        pr_partial = '0;
                    end else begin
                        pr_partial = pr_partial | (24'(data_byte) << (8 * pos));
                    end
                end
            end else begin
                // Done: padded partial word, trailer, then the seven header words.
                n_data_words = (int'(pr_count) + 3) >> 2;
                total        = ebf_pkg::HDR_BYTES + 32'(4 * n_data_words);
                if (pr_count[1:0] != 2'd0) begin
                    words[n] = mk_word(int'(ebf_pkg::DATA_BASE) + int'(pr_count >> 2),
                                       {8'h00, pr_partial}, 1'b0);
                    n++;
                end
                words[n]     = mk_word(int'(ebf_pkg::DATA_BASE) + n_data_words, total, 1'b0);
                words[n + 1] = mk_word(int'(ebf_pkg::ADDR_TYPE), ebf_pkg::BLOCK_TYPE_EPB, 1'b0);
                words[n + 2] = mk_word(int'(ebf_pkg::ADDR_TOTAL), total, 1'b0);
                words[n + 3] = mk_word(int'(ebf_pkg::ADDR_IFACE), pr_iface, 1'b0);
                words[n + 4] = mk_word(int'(ebf_pkg::ADDR_TS_HI), pr_ts[63:32], 1'b0);
                words[n + 5] = mk_word(int'(ebf_pkg::ADDR_TS_LO), pr_ts[31:0], 1'b0);
                words[n + 6] = mk_word(int'(ebf_pkg::ADDR_CAPLEN), 32'(pr_count), 1'b0);
                words[n + 7] = mk_word(int'(ebf_pkg::ADDR_PKTLEN), 32'(pr_count), 1'b1);
                n            = n + 8;
                pr_open      = 1'b0;
                pr_partial   = '0;
            end
        end
    endtask

    // Offers one item, waits for its transfer, records the predicted words and then
    // paces the sender: bursts of random length with random gaps between them.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] iface,
                             input logic [63:0] ts, input logic [7:0] data_byte,
                             output t_block_word words [MAX_WORDS], output int n);
        bit effective;
        int k;
        i_valid     = 1'b1;
        i_kind      = kind;
        i_iface     = iface;
        i_timestamp = ts;
        i_data_byte = data_byte;
        do @(posedge i_clk); while (!o_ready);
        predict_block_words(kind, iface, ts, data_byte, words, n, effective);
        for (k = 0; k < n; k++) pending_words.push_back(words[k]);
        if (effective) items_taken++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic offer_random(input logic [1:0] kind);
        t_block_word words [MAX_WORDS];
        int          n;
        send_item(kind, $urandom, {$urandom, $urandom}, 8'($urandom), words, n);
    endtask

    // Stops offering items until every predicted word has been transferred out.
    task automatic wait_for_block_words();
        i_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output checker: each output transfer is compared with the oldest predicted word.
    always @(posedge i_clk) begin : check_words
        t_block_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: word_addr %0d word_data %h", o_word_addr, o_word_data);
                n_fail++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_word_addr !== exp_w.addr) begin
                    $error("word_addr: expected %0d, actual %0d", exp_w.addr, o_word_addr);
                    n_fail++;
                end
                if (o_word_data !== exp_w.data) begin
                    $error("word_data: expected %h, actual %h", exp_w.data, o_word_data);
                    n_fail++;
                end
                if (o_truncated !== exp_w.trunc) begin
                    $error("truncated: expected %0d, actual %0d", exp_w.trunc, o_truncated);
                    n_fail++;
                end
                if (o_last_word !== exp_w.last) begin
                    $error("last_word: expected %0d, actual %0d", exp_w.last, o_last_word);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either channel means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: switches between stall patterns of its own, and on request holds off for
    // a long stretch so the command queue fills and the input side stalls.
    initial begin : receiver
        int mode;
        int mode_left;
        int phase;
        int holds_done;
        mode       = RX_FREE;
        mode_left  = 0;
        phase      = 0;
        holds_done = 0;
        i_ready    = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                i_ready    = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_FREE, RX_PERIODIC);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_FREE:   i_ready = 1'b1;
                    RX_RANDOM: i_ready = ($urandom_range(0, 2) != 0);
                    default:   i_ready = ((phase % 7) >= 3);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_block_word words [MAX_WORDS];
        int          n;
        int          r;
        int          pick;
        int          len;
        int          j;
        int          next_hold;
        bit          paused;
        t_stim_row   row;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = ebf_pkg::KIND_START;
        i_iface     = '0;
        i_timestamp = '0;
        i_data_byte = '0;
        pr_open     = 1'b0;
        pr_count    = '0;
        pr_partial  = '0;
        pr_iface    = '0;
        pr_ts       = '0;
        pr_overflow = 1'b0;
        paused      = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows.
        for (r = 0; r < NUM_ROWS; r++) begin
            row = STIM_TAB[r];
            send_item(row.kind, row.iface, row.ts, row.data_byte, words, n);
            if (row.typed) begin
                if (n != int'(row.n_words)) begin
                    $error("row %0d word count: expected %0d, actual %0d", r, row.n_words, n);
                    n_row_fail++;
                end else if (n > 0 && words[0].addr != row.addr) begin
                    $error("row %0d word_addr: expected %0d, actual %0d",
                           r, row.addr, words[0].addr);
                    n_row_fail++;
                end else if (n > 0 && words[0].data != row.data) begin
                    $error("row %0d word_data: expected %h, actual %h",
                           r, row.data, words[0].data);
                    n_row_fail++;
                end
            end
        end
        wait_for_block_words();

        // Random part: mostly well-formed packets with random content, the rest noise
        // and blocks left open for a later start to abandon.
        items_taken = 0;
        next_hold   = 60;
        while (items_taken < RAND_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                offer_random(ebf_pkg::KIND_START);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(0, 12);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 15) == 0) offer_random(KIND_UNDEF);
                    offer_random(ebf_pkg::KIND_DATA);
                end
                offer_random(ebf_pkg::KIND_DONE);
            end else if (pick < 18) begin
                offer_random(2'($urandom_range(0, 3)));
            end else begin
                offer_random(ebf_pkg::KIND_START);
                repeat ($urandom_range(0, 6)) offer_random(ebf_pkg::KIND_DATA);
            end
            if (items_taken >= next_hold) begin
                hold_reqs++;
                next_hold = next_hold + 110;
            end
            if (!paused && items_taken >= RAND_ITEMS / 2) begin
                wait_for_block_words();
                paused = 1'b1;
            end
        end

        wait_for_block_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && n_row_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
